>>> hdl/dtad_pkg.sv
package dtad_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_READS_DEF   = 64;

    // Field and state widths
    localparam int RC_W    = 7;    // read count register
    localparam int HYST_W  = 14;   // hysteresis fraction
    localparam int GAIN_W  = 16;   // Q0.16 filter gains
    localparam int ACCUM_W = 16;   // burst sum
    localparam int LEVEL_W = 32;   // Q16.16 level
    localparam int LIMIT_W = 33;   // Q17.16 limit
    localparam int MUL_W   = 17;   // multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 51;   // partial product accumulator
    localparam int HI_W    = ACC_W - 16;

    // Fixed point constants
    localparam logic [MUL_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0]      HALF_Q16 = 16'h8000;

    // APB port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [RC_W-1:0]   RST_READ_COUNT = 7'd40;
    localparam logic [HYST_W-1:0] RST_HYST       = 14'd3277;
    localparam logic [GAIN_W-1:0] RST_FGAIN      = 16'd16384;
    localparam logic [GAIN_W-1:0] RST_TGAIN      = 16'd1966;
    localparam logic              RST_INVERT     = 1'b0;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_READ_COUNT = 3'd0,
        REG_HYST       = 3'd1,
        REG_FGAIN      = 3'd2,
        REG_TGAIN      = 3'd3,
        REG_INVERT     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [RC_W-1:0]   read_count;
        logic [HYST_W-1:0] hyst;
        logic [GAIN_W-1:0] filter_gain;
        logic [GAIN_W-1:0] threshold_gain;
        logic              invert;
    } t_cfg;

    // Datapath step codes, one multiply each except the idle and flag steps
    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_INIT,   // level <= S<<16, flag cleared, mult S*(1+4f)
        STEP_TGT,    // mult S*(1 -/+ f)
        STEP_GS,     // mult g*S
        STEP_LLO,    // mult (1-g)*level[15:0]
        STEP_LHI,    // mult (1-g)*level[31:16]
        STEP_HLO,    // mult h*target[15:0]
        STEP_HHI,    // mult h*target[32:16]
        STEP_MLO,    // mult (1-h)*limit[15:0]
        STEP_MHI,    // mult (1-h)*limit[32:16]
        STEP_FLAG    // compare, load result
    } t_step;

    typedef struct packed {
        t_step step;
        logic  sample_add;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_TGT,
        ST_GS,
        ST_LLO,
        ST_LHI,
        ST_HLO,
        ST_HHI,
        ST_MLO,
        ST_MHI,
        ST_DRAIN,
        ST_FLAG
    } t_state;

endpackage

>>> hdl/dual_touch_adaptive_detector_unit.sv
// Dual capacitive touch detector with baseline tracking.
//
// Input channel (i_in_valid / o_in_stall) carries one left/right ADC sample
// pair per item. Items are grouped in bursts of read_count+1, with read_count
// capped at MAX_READS; the first item of a burst is dropped and the rest are
// summed per channel with saturation. Within a burst one item is taken every
// cycle. After the last item of a burst the block stalls its input while one
// 17x17 multiplier per channel runs the level and limit filter updates, one
// partial product per cycle. The result item (o_out_valid / i_out_stall) is
// loaded at the end of the update sequence and holds both touch flags and
// both burst sums in an output register until taken. While it waits,
// the next burst is accepted; a burst that finishes before the result is
// taken holds in its last step until the output register frees up.
// Registers are written over the APB port at byte addresses 0, 4, .. 16;
// writes are meant for idle periods between bursts.
// Reset restores register defaults, clears running sums, filters and flags, and the
// first burst after reset seeds the level and limit filters.
module dual_touch_adaptive_detector_unit import dtad_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_READS   = MAX_READS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // sample input
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_left_touched,
    output logic                   o_right_touched,
    output logic [ACCUM_W-1:0]     o_left_total,
    output logic [ACCUM_W-1:0]     o_right_total
);

    t_cfg cfg;
    t_cmd cmd;

    dtad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dtad_ctrl #(
        .MAX_READS (MAX_READS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    dtad_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .i_sample  (i_left_sample),
        .o_touched (o_left_touched),
        .o_total   (o_left_total)
    );

    dtad_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .i_sample  (i_right_sample),
        .o_touched (o_right_touched),
        .o_total   (o_right_total)
    );

endmodule

>>> hdl/dtad_regs.sv
module dtad_regs import dtad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_count     <= RST_READ_COUNT;
            r_cfg.hyst           <= RST_HYST;
            r_cfg.filter_gain    <= RST_FGAIN;
            r_cfg.threshold_gain <= RST_TGAIN;
            r_cfg.invert         <= RST_INVERT;
        end else if (wr_en) begin
            unique case (idx)
                REG_READ_COUNT: r_cfg.read_count     <= pwdata[RC_W-1:0];
                REG_HYST:       r_cfg.hyst           <= pwdata[HYST_W-1:0];
                REG_FGAIN:      r_cfg.filter_gain    <= pwdata[GAIN_W-1:0];
                REG_TGAIN:      r_cfg.threshold_gain <= pwdata[GAIN_W-1:0];
                REG_INVERT:     r_cfg.invert         <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_READ_COUNT: prdata = DATA_W'(r_cfg.read_count);
            REG_HYST:       prdata = DATA_W'(r_cfg.hyst);
            REG_FGAIN:      prdata = DATA_W'(r_cfg.filter_gain);
            REG_TGAIN:      prdata = DATA_W'(r_cfg.threshold_gain);
            REG_INVERT:     prdata = DATA_W'(r_cfg.invert);
            default:        prdata = '0;
        endcase
    end

endmodule

>>> hdl/dtad_chan.sv
module dtad_chan import dtad_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_touched,
    output logic [ACCUM_W-1:0]     o_total
);

    logic [ACCUM_W-1:0] r_accum;
    logic [ACCUM_W-1:0] r_total;
    logic [LEVEL_W-1:0] r_level;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] r_target;
    logic               r_flag;
    logic [ACC_W-1:0]   r_acc;
    logic [PROD_W-1:0]  r_prod;
    t_step              r_wb;

    logic [MUL_W-1:0]   ng, nh, up, act, s17;
    logic [MUL_W-1:0]   op_a, op_b;
    logic [PROD_W-1:0]  prod;
    logic [ACCUM_W:0]   sum17;
    logic [ACCUM_W-1:0] accum_sat;
    logic [ACC_W-1:0]   acc_lo_sum, acc_hi_sum;
    logic [HI_W-1:0]    hi;
    logic [LEVEL_W-1:0] level_sat;
    logic [LIMIT_W-1:0] limit_sat;
    logic               flag_new;

    assign o_touched = r_flag;
    assign o_total   = r_total;

    // Gain complements and hysteresis factors, all 17 bits
    assign ng  = ONE_Q16 - {1'b0, i_cfg.filter_gain};
    assign nh  = ONE_Q16 - {1'b0, i_cfg.threshold_gain};
    assign up  = ONE_Q16 + {1'b0, i_cfg.hyst, 2'b00};
    assign act = r_flag ? (ONE_Q16 - {3'b000, i_cfg.hyst})
                        : (ONE_Q16 + {3'b000, i_cfg.hyst});
    assign s17 = {1'b0, r_accum};

    // Multiplier operand select
    always_comb begin
        case (i_cmd.step)
            STEP_INIT: begin op_a = s17;                  op_b = up;                end
            STEP_TGT:  begin op_a = s17;                  op_b = act;               end
            STEP_GS:   begin op_a = {1'b0, i_cfg.filter_gain}; op_b = s17;          end
            STEP_LLO:  begin op_a = ng;                   op_b = {1'b0, r_level[15:0]};  end
            STEP_LHI:  begin op_a = ng;                   op_b = {1'b0, r_level[31:16]}; end
            STEP_HLO:  begin op_a = {1'b0, i_cfg.threshold_gain};
                             op_b = {1'b0, r_target[15:0]}; end
            STEP_HHI:  begin op_a = {1'b0, i_cfg.threshold_gain};
                             op_b = r_target[32:16]; end
            STEP_MLO:  begin op_a = nh;                   op_b = {1'b0, r_limit[15:0]};  end
            STEP_MHI:  begin op_a = nh;                   op_b = r_limit[32:16];         end
            default:   begin op_a = '0;                   op_b = '0;                end
        endcase
    end

    assign prod = PROD_W'(op_a) * PROD_W'(op_b);

    // Saturating burst sum
    assign sum17     = {1'b0, r_accum} + (ACCUM_W+1)'(i_sample);
    assign accum_sat = sum17[ACCUM_W] ? '1 : sum17[ACCUM_W-1:0];

    // Product accumulation and rounding back to Q16
    assign acc_lo_sum = r_acc + ACC_W'(r_prod);
    assign acc_hi_sum = r_acc + (ACC_W'(r_prod) << 16);
    assign hi         = acc_hi_sum[ACC_W-1:16];
    assign level_sat  = (|hi[HI_W-1:LEVEL_W]) ? '1 : hi[LEVEL_W-1:0];
    assign limit_sat  = (|hi[HI_W-1:LIMIT_W]) ? '1 : hi[LIMIT_W-1:0];

    assign flag_new = ((LIMIT_W'(r_level) > r_limit) ? 1'b1 : 1'b0) ^ i_cfg.invert;

    // Channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb    <= STEP_IDLE;
            r_accum <= '0;
            r_level <= '0;
            r_limit <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_wb <= i_cmd.step;
            if (i_cmd.sample_add) begin
                r_accum <= accum_sat;
            end
            // issue-time actions
            case (i_cmd.step)
                STEP_INIT: begin
                    r_level <= {r_accum, 16'h0000};
                    r_flag  <= 1'b0;
                end
                STEP_FLAG: begin
                    r_flag  <= flag_new;
                    r_accum <= '0;
                end
                default: ;
            endcase
            // writeback of the previous product
            case (r_wb)
                STEP_INIT: r_limit <= r_prod[LIMIT_W-1:0];
                STEP_LHI:  r_level <= level_sat;
                STEP_MHI:  r_limit <= limit_sat;
                default: ;
            endcase
        end
    end

    // Product pipeline and accumulator
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_cmd.step == STEP_FLAG) begin
            r_total <= r_accum;
        end
        case (r_wb)
            STEP_TGT: r_target <= r_prod[LIMIT_W-1:0];
            STEP_GS:  r_acc    <= ACC_W'(HALF_Q16) + (ACC_W'(r_prod) << 16);
            STEP_LLO: r_acc    <= acc_lo_sum;
            STEP_HLO: r_acc    <= ACC_W'(HALF_Q16) + ACC_W'(r_prod);
            STEP_HHI: r_acc    <= acc_hi_sum;
            STEP_MLO: r_acc    <= acc_lo_sum;
            default: ;
        endcase
    end

endmodule

>>> hdl/dtad_ctrl.sv
module dtad_ctrl import dtad_pkg::*; #(
    parameter int MAX_READS = MAX_READS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam int              PW       = $clog2(MAX_READS + 1);
    localparam logic [RC_W-1:0] MAX_RC   = RC_W'(MAX_READS);

    t_state          r_state, n_state;
    logic [PW-1:0]   r_pos, n_pos;
    logic            r_initialized, n_initialized;
    logic            r_out_valid, n_out_valid;
    logic [RC_W-1:0] eff;
    logic            in_accept;

    assign eff         = (i_cfg.read_count > MAX_RC) ? MAX_RC : i_cfg.read_count;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_initialized <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pos         <= n_pos;
            r_initialized <= n_initialized;
            r_out_valid   <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_pos            = r_pos;
        n_initialized    = r_initialized;
        n_out_valid      = r_out_valid && i_out_stall;
        o_cmd.step       = STEP_IDLE;
        o_cmd.sample_add = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    // first item of a burst is dropped
                    o_cmd.sample_add = (r_pos != '0);
                    if (RC_W'(r_pos) < eff) begin
                        n_pos = r_pos + PW'(1);
                    end else begin
                        n_pos   = '0;
                        n_state = r_initialized ? ST_TGT : ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.step    = STEP_INIT;
                n_initialized = 1'b1;
                n_state       = ST_TGT;
            end
            ST_TGT: begin
                o_cmd.step = STEP_TGT;
                n_state    = ST_GS;
            end
            ST_GS: begin
                o_cmd.step = STEP_GS;
                n_state    = ST_LLO;
            end
            ST_LLO: begin
                o_cmd.step = STEP_LLO;
                n_state    = ST_LHI;
            end
            ST_LHI: begin
                o_cmd.step = STEP_LHI;
                n_state    = ST_HLO;
            end
            ST_HLO: begin
                o_cmd.step = STEP_HLO;
                n_state    = ST_HHI;
            end
            ST_HHI: begin
                o_cmd.step = STEP_HHI;
                n_state    = ST_MLO;
            end
            ST_MLO: begin
                o_cmd.step = STEP_MLO;
                n_state    = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.step = STEP_MHI;
                n_state    = ST_DRAIN;
            end
            ST_DRAIN: begin
                // last limit writeback
                n_state = ST_FLAG;
            end
            ST_FLAG: begin
                // load result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.step  = STEP_FLAG;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
